[hdl/svn_pkg.sv]
`default_nettype none
package svn_pkg;
    localparam int CAPACITY    = 4096;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int POS_BITS    = ADDR_BITS + 1;

    localparam logic [1:0] REG_STATE_COUNT = 2'd0;
    localparam logic [1:0] REG_POINTS      = 2'd1;
    localparam logic [1:0] REG_GRID_STEP   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_ZERO_NORM = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] sample;
        logic [11:0] index;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_out_beat;

    // Start request and result from the norm unit
    typedef struct packed {
        logic         start;
        logic [111:0] m;
    } t_norm_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [47:0] inv;
    } t_norm_rsp;
endpackage
`default_nettype wire

[hdl/svn_if.sv]
`default_nettype none
interface svn_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/simpson_vector_normalizer.sv]
`default_nettype none
// Channel | Dir | Payload
// in_ch   | in  | cmd, sample, index
// out_ch  | out | value, status
// A load is taken, goes through one multiply of the shared unit, then is accumulated.
// After a read is taken it passes a memory read, two multiplies and a result stage
// before its result beat is valid; the next beat is taken in the cycle after it leaves.
// The last load then forms M and runs the 48-bit norm search.
// Reset is synchronous; the sample memory keeps its contents.
// The output holds until taken; no new beat is taken meanwhile.
module simpson_vector_normalizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    svn_if.sink              in_ch,
    svn_if.source            out_ch,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import svn_pkg::*;

    typedef enum logic [3:0] {S_IDLE, S_LMUL, S_LACC, S_MMUL, S_RMEM, S_RMUL0, S_RMUL1,
                              S_OUT, S_NORM} t_state;

    t_state          r_state;
    logic [6:0]      r_sc;
    logic [12:0]     r_pps;
    logic [31:0]     r_h;
    logic [79:0]     r_sum;
    logic [POS_BITS-1:0] r_lpos;
    logic [11:0]     r_spos;
    logic [47:0]     r_inv;
    logic            r_ready;
    logic [31:0]     r_mag;
    logic            r_neg;
    logic [1:0]      r_wsh;
    logic            r_wz;
    logic [63:0]     r_hip;
    logic [31:0]     r_mem_q;
    logic [31:0]     r_val;
    logic [1:0]      r_status;
    logic            r_ovalid;
    logic            r_last;
    logic [11:0]     r_ridx;
    logic [1:0]      r_mi;
    logic [31:0]     mem [CAPACITY];

    t_in_beat w_in;
    assign w_in = in_ch.data;

    logic [19:0] w_total;
    logic        w_cfg_ok;
    assign w_total  = 20'(r_sc) * 20'(r_pps);
    assign w_cfg_ok = (r_sc != 7'd0) && (r_pps >= 13'd2) && (w_total <= 20'(CAPACITY));

    // Length used for the Simpson weights: the point count rounded down to even
    logic [12:0] w_len;
    assign w_len = {r_pps[12:1], 1'b0};

    logic [31:0] w_in_mag;
    assign w_in_mag = w_in.sample[31] ? (32'd0 - w_in.sample) : w_in.sample;
    logic [31:0] w_q_mag;
    assign w_q_mag = r_mem_q[31] ? (32'd0 - r_mem_q) : r_mem_q;

    // Limb of the sum that is multiplied by the step while M is formed
    logic [31:0] w_m_limb;
    always_comb begin
        unique case (r_mi)
            2'd0:    w_m_limb = r_sum[31:0];
            2'd1:    w_m_limb = r_sum[63:32];
            default: w_m_limb = {16'd0, r_sum[79:64]};
        endcase
    end

    // Shared multiplier and norm unit
    t_norm_req   w_nreq;
    t_norm_rsp   w_nrsp;
    logic [31:0] w_na, w_nb, w_ma, w_mb;
    logic [63:0] w_mp;
    logic        w_nbusy;
    assign w_nbusy = (r_state == S_NORM);

    always_comb begin
        if (w_nbusy) begin
            w_ma = w_na; w_mb = w_nb;
        end else if (r_state == S_MMUL) begin
            w_ma = w_m_limb; w_mb = r_h;
        end else if (r_state == S_RMUL0) begin
            w_ma = r_mag; w_mb = {16'd0, r_inv[47:32]};
        end else if (r_state == S_RMUL1) begin
            w_ma = r_mag; w_mb = r_inv[31:0];
        end else begin
            w_ma = r_mag; w_mb = r_mag;
        end
    end

    svn_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));

    // M = H * S is formed on the shared multiplier, one 32-bit limb of S a cycle;
    // each product arrives in the following cycle and is added at its limb position.
    logic [111:0] w_m_part;
    always_comb begin
        unique case (r_mi)
            2'd1:    w_m_part = 112'(w_mp);
            2'd2:    w_m_part = 112'(w_mp) << 32;
            2'd3:    w_m_part = 112'(w_mp) << 64;
            default: w_m_part = 112'd0;
        endcase
    end

    logic [111:0] r_m;
    logic         r_mstart;
    assign w_nreq.start = r_mstart;
    assign w_nreq.m     = r_m;

    svn_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_nreq), .o_rsp(w_nrsp),
        .o_ma(w_na), .o_mb(w_nb), .i_mp(w_mp), .i_mul_grant(w_nbusy)
    );

    assign in_ch.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = {r_val, r_status};

    logic w_acc_in;
    assign w_acc_in = in_ch.valid && in_ch.ready;

    // Sample memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_acc_in && w_in.cmd == CMD_LOAD && w_cfg_ok
            && (r_ready || 20'(r_lpos) < w_total))
            mem[r_ready ? ADDR_BITS'(0) : r_lpos[ADDR_BITS-1:0]] <= w_in.sample;
        r_mem_q <= mem[w_in.index[ADDR_BITS-1:0]];
    end

    logic [79:0] w_sq_sh;
    assign w_sq_sh = 80'(w_mp) << r_wsh;
    logic [63:0] w_res;
    assign w_res = (r_hip >> 2) + 64'(((64'(r_hip[1:0]) << 30) + (w_mp >> 2)) >> 32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sc     <= 7'd1;
            r_pps    <= 13'd2;
            r_h      <= 32'h0100_0000;
            r_sum    <= 80'd0;
            r_lpos   <= '0;
            r_spos   <= 12'd0;
            r_inv    <= 48'd0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_mstart <= (r_state == S_MMUL) && (r_mi == 2'd3);
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (i_cfg_we && (i_cfg_idx == REG_STATE_COUNT || i_cfg_idx == REG_POINTS
                             || i_cfg_idx == REG_GRID_STEP)) begin
                unique case (i_cfg_idx)
                    REG_STATE_COUNT: r_sc  <= i_cfg_data[6:0];
                    REG_POINTS:      r_pps <= i_cfg_data[12:0];
                    REG_GRID_STEP:   r_h   <= i_cfg_data;
                    default:         r_h   <= r_h;
                endcase
                r_sum <= 80'd0; r_lpos <= '0; r_spos <= 12'd0;
                r_inv <= 48'd0; r_ready <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in && w_in.cmd == CMD_LOAD) begin
                        if (w_cfg_ok && (r_ready || 20'(r_lpos) < w_total)) begin
                            logic [11:0] k;
                            k = r_ready ? 12'd0 : r_spos;
                            if (r_ready) begin
                                r_sum <= 80'd0; r_lpos <= '0; r_inv <= 48'd0;
                                r_ready <= 1'b0;
                            end
                            r_mag <= w_in_mag;
                            r_wz  <= (13'(k) >= w_len);
                            r_wsh <= (k == 12'd0 || 13'(k) == w_len - 13'd1) ? 2'd0 :
                                     (k[0] ? 2'd2 : 2'd1);
                            r_spos <= (13'(k) + 13'd1 >= r_pps) ? 12'd0 : k + 12'd1;
                            r_last <= (20'(r_ready ? '0 : r_lpos) + 20'd1 == w_total);
                            r_state <= S_LMUL;
                        end
                    end else if (w_acc_in) begin
                        r_ridx  <= w_in.index;
                        r_state <= S_RMEM;
                    end
                end
                S_LMUL: r_state <= S_LACC;
                S_LACC: begin
                    if (!r_wz) r_sum <= r_sum + w_sq_sh;
                    r_lpos <= r_lpos + POS_BITS'(1);
                    if (r_last) begin
                        r_m     <= 112'd0;
                        r_mi    <= 2'd0;
                        r_state <= S_MMUL;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_MMUL: begin
                    r_m <= r_m + w_m_part;
                    if (r_mi == 2'd3) r_state <= S_NORM;
                    else r_mi <= r_mi + 2'd1;
                end
                S_NORM: begin
                    if (w_nrsp.done) begin
                        r_inv   <= w_nrsp.inv;
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_RMEM: begin
                    r_mag   <= w_q_mag;
                    r_neg   <= r_mem_q[31];
                    r_state <= S_RMUL0;
                end
                S_RMUL0: r_state <= S_RMUL1;
                S_RMUL1: begin
                    r_hip   <= w_mp;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    if (!r_ready || !w_cfg_ok || 20'(r_ridx) >= w_total) begin
                        r_status <= ST_NOT_READY;
                        r_val    <= 32'd0;
                    end else if (r_inv == 48'd0) begin
                        r_status <= ST_ZERO_NORM;
                        r_val    <= 32'd0;
                    end else begin
                        r_status <= ST_OK;
                        if (r_neg) r_val <= (w_res > 64'h8000_0000) ? 32'h8000_0000 :
                                            32'd0 - w_res[31:0];
                        else r_val <= (w_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_res[31:0];
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_take_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !in_ch.ready) else $error("input taken while result waits");
    a_ready_after_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM && w_nrsp.done) |=> r_ready) else $error("norm lost");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_status != 2'd3)) else $error("bad status");
`endif
endmodule
`default_nettype wire

[hdl/svn_mul.sv]
`default_nettype none
// Shared 32x32 multiplier with a registered product.
module svn_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end
    assign o_p = r_p;
endmodule
`default_nettype wire

[hdl/svn_norm.sv]
`default_nettype none
// Bit-by-bit search for the largest v with v*v*M <= 3*2^148.
// For each bit the shared multiplier first forms v*v from 32-bit partial products,
// then (v*v)*M from 32-bit partials over 3x4 limbs.
module svn_norm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire svn_pkg::t_norm_req i_req,
    output svn_pkg::t_norm_rsp      o_rsp,
    output logic             [31:0] o_ma,
    output logic             [31:0] o_mb,
    input  wire logic        [63:0] i_mp,
    input  wire logic               i_mul_grant
);
    import svn_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQ_ACC, S_PR, S_PR_ACC, S_CMP} t_state;

    localparam logic [223:0] LIMIT = 224'(3) << 148;

    t_state       r_state;
    logic [5:0]   r_bit;
    logic [47:0]  r_val;
    logic [47:0]  r_cand;
    logic [111:0] r_m;
    logic [95:0]  r_sq;
    logic [223:0] r_acc;
    logic [3:0]   r_pi;
    logic         r_done;

    // The first product pass reads v*v while r_sq is loaded, so feed it from r_acc then.
    logic [95:0] w_sq;
    assign w_sq = (r_pi == 4'd0) ? r_acc[95:0] : r_sq;

    // Operand selection for the partial product at r_pi
    logic [1:0] w_ia;
    logic [1:0] w_ib;
    always_comb begin
        w_ia = r_pi[3:2];
        w_ib = r_pi[1:0];
        o_ma = 32'd0;
        o_mb = 32'd0;
        if (r_state == S_SQ) begin
            o_ma = w_ia[0] ? {16'd0, r_cand[47:32]} : r_cand[31:0];
            o_mb = w_ib[0] ? {16'd0, r_cand[47:32]} : r_cand[31:0];
        end else if (r_state == S_PR) begin
            unique case (w_ia)
                2'd0:    o_ma = w_sq[31:0];
                2'd1:    o_ma = w_sq[63:32];
                2'd2:    o_ma = w_sq[95:64];
                default: o_ma = 32'd0;
            endcase
            unique case (w_ib)
                2'd0:    o_mb = r_m[31:0];
                2'd1:    o_mb = r_m[63:32];
                2'd2:    o_mb = r_m[95:64];
                default: o_mb = {16'd0, r_m[111:96]};
            endcase
        end
    end

    logic [7:0] w_sh;
    assign w_sh = {1'b0, r_pi[3:2], 5'd0} + {1'b0, r_pi[1:0], 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_val   <= 48'd0;
        end else begin
            r_done <= ((r_state == S_IDLE) && i_req.start && (i_req.m == 112'd0))
                      || ((r_state == S_CMP) && (r_bit == 6'd0));
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_m <= i_req.m;
                        if (i_req.m == 112'd0) begin
                            r_val <= 48'd0;
                        end else begin
                            r_val   <= 48'd0;
                            r_cand  <= 48'h8000_0000_0000;
                            r_bit   <= 6'd47;
                            r_acc   <= 224'd0;
                            r_pi    <= 4'd0;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: if (i_mul_grant) r_state <= S_SQ_ACC;
                S_SQ_ACC: begin
                    r_acc <= r_acc + (224'(i_mp) << w_sh);
                    if (r_pi == 4'd5) begin
                        r_pi    <= 4'd0;
                        r_state <= S_PR;
                    end else begin
                        // 2x2 limbs: indices 0,1,4,5
                        r_pi    <= (r_pi == 4'd1) ? 4'd4 : r_pi + 4'd1;
                        r_state <= S_SQ;
                    end
                end
                S_PR: begin
                    if (r_pi == 4'd0) begin
                        r_sq  <= r_acc[95:0];
                        r_acc <= 224'd0;
                    end
                    r_state <= S_PR_ACC;
                end
                S_PR_ACC: begin
                    r_acc <= r_acc + (224'(i_mp) << w_sh);
                    if (r_pi == 4'd11) r_state <= S_CMP;
                    else begin
                        r_pi    <= r_pi + 4'd1;
                        r_state <= S_PR;
                    end
                end
                S_CMP: begin
                    if (r_acc <= LIMIT) r_val <= r_cand;
                    r_acc <= 224'd0;
                    r_pi  <= 4'd0;
                    if (r_bit == 6'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_bit   <= r_bit - 6'd1;
                        r_cand  <= ((r_acc <= LIMIT) ? r_cand : r_val)
                                   | (48'd1 << (r_bit - 6'd1));
                        r_state <= S_SQ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_state != S_IDLE) || r_done;
    assign o_rsp.done = r_done;
    assign o_rsp.inv  = r_val;
endmodule
`default_nettype wire

[test/simpson_vector_normalizer_tb.sv]
`default_nettype none
module simpson_vector_normalizer_tb;
    import svn_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 2000;

    // Holds the expected behaviour of the normalizer and the results still owed.
    class norm_scoreboard;
        bit [6:0]    n_states;
        bit [12:0]   n_points;
        bit [31:0]   step;
        bit [31:0]   store [CAPACITY];
        bit [127:0]  acc;
        int unsigned fill;
        int unsigned seg;
        bit [47:0]   inv;
        bit          have_norm;
        t_out_beat   owed [$];
        int          errors;
        int          results_seen;

        function void clear_progress();
            acc       = '0;
            fill      = 0;
            seg       = 0;
            inv       = '0;
            have_norm = 1'b0;
        endfunction

        function void reset_state();
            n_states = 7'd1;
            n_points = 13'd2;
            step     = 32'd16777216;
            clear_progress();
        endfunction

        function int unsigned total();
            return int'(n_states) * int'(n_points);
        endfunction

        function bit cfg_ok();
            return n_states >= 1 && n_points >= 2 && total() <= CAPACITY;
        endfunction

        function void write_reg(bit [1:0] idx, bit [31:0] d);
            case (idx)
                REG_STATE_COUNT: n_states = d[6:0];
                REG_POINTS:      n_points = d[12:0];
                REG_GRID_STEP:   step = d;
                default:         return;
            endcase
            clear_progress();
        endfunction

        function bit [32:0] magnitude(bit [31:0] raw);
            bit [32:0] m;
            m = {1'b0, raw};
            if (raw[31]) m = 33'h1_0000_0000 - m;
            return m;
        endfunction

        // Bitwise search for the largest v with v*v*step*sum <= 3 * 2^148.
        function bit [47:0] solve_inverse();
            bit [223:0] m;
            bit [223:0] c;
            bit [223:0] lim;
            bit [47:0]  v;
            m   = 224'(acc) * 224'(step);
            lim = 224'd3 << 148;
            v   = '0;
            if (m == 0) return '0;
            for (int b = 47; b >= 0; b--) begin
                c = 224'(v | (48'd1 << b));
                if (c * c * m <= lim) v = c[47:0];
            end
            return v;
        endfunction

        function void note_beat(t_in_beat b);
            bit [32:0]   m;
            bit [63:0]   sq;
            int unsigned len;
            int unsigned w;
            bit [95:0]   prod;
            bit [95:0]   res;
            t_out_beat   r;
            if (b.cmd == CMD_LOAD) begin
                if (!cfg_ok()) return;
                if (have_norm) clear_progress();
                if (fill >= total()) return;
                store[fill] = b.sample;
                m   = magnitude(b.sample);
                sq  = 64'(m) * 64'(m);
                len = int'(n_points) & ~1;
                w   = 0;
                if (seg < len) begin
                    if (seg == 0 || seg == len - 1) w = 1;
                    else if (seg[0]) w = 4;
                    else w = 2;
                end
                acc += 128'(sq) * 128'(w);
                fill++;
                seg++;
                if (seg >= n_points) seg = 0;
                if (fill == total()) begin
                    inv       = solve_inverse();
                    have_norm = 1'b1;
                end
            end else begin
                r = '0;
                if (!have_norm || !cfg_ok() || b.index >= total()) begin
                    r.status = ST_NOT_READY;
                end else if (inv == 0) begin
                    r.status = ST_ZERO_NORM;
                end else begin
                    m    = magnitude(store[b.index]);
                    prod = 96'(m) * 96'(inv);
                    res  = prod >> 34;
                    if (store[b.index][31]) begin
                        if (res > 96'h8000_0000) res = 96'h8000_0000;
                        r.value = -res[31:0];
                    end else begin
                        if (res > 96'h7FFF_FFFF) res = 96'h7FFF_FFFF;
                        r.value = res[31:0];
                    end
                    r.status = ST_OK;
                end
                owed.push_back(r);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp_v);
            $display("mismatch on result %0d: %s got %h, wanted %h",
                     results_seen, what, got, exp_v);
            errors++;
        endtask

        task check_result(t_out_beat r);
            t_out_beat e;
            results_seen++;
            if (owed.size() == 0) begin
                report("unexpected beat, value", r.value, 32'h0);
                return;
            end
            e = owed.pop_front();
            if (r.status !== e.status) report("status", 32'(r.status), 32'(e.status));
            if (r.value !== e.value) report("value", r.value, e.value);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    svn_if #(.W($bits(t_in_beat)))  in_ch ();
    svn_if #(.W($bits(t_out_beat))) out_ch ();

    simpson_vector_normalizer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    norm_scoreboard sb;
    bit idle_on;
    int cycles;
    int n_loads;
    int n_reads;
    int n_settings;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle count and timeout.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** simpson_vector_normalizer: FAILED **");
            $finish;
        end
    end

    // Note every accepted input beat and check every accepted result beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) sb.note_beat(t_in_beat'(in_ch.data));
            if (out_ch.valid && out_ch.ready) sb.check_result(t_out_beat'(out_ch.data));
        end
    end

    // Receiver: ready with random stall bursts while idling is enabled.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
        end
    end

    task automatic send(bit c, bit [31:0] s, bit [11:0] ix);
        t_in_beat b;
        b.cmd    = c;
        b.sample = s;
        b.index  = ix;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = b;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        if (c == CMD_LOAD) n_loads++;
        else n_reads++;
    endtask

    task automatic load(bit [31:0] s);
        send(CMD_LOAD, s, 12'($urandom));
    endtask

    task automatic read(bit [11:0] ix);
        send(CMD_READ, $urandom, ix);
    endtask

    task automatic wait_drained();
        while (sb.owed.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Registers change only once the block is quiet, including a running norm search.
    task automatic set_regs(bit [6:0] states, bit [12:0] points, bit [31:0] stp);
        bit [31:0] vals [3];
        vals[0] = 32'(states);
        vals[1] = 32'(points);
        vals[2] = stp;
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        for (int r = 0; r < 3; r++) begin
            i_cfg_we   = 1'b1;
            i_cfg_idx  = 2'(r);
            i_cfg_data = vals[r];
            sb.write_reg(2'(r), vals[r]);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        n_settings++;
    endtask

    function automatic bit [31:0] pick_sample(int style);
        bit [31:0] pool [5];
        pool = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0};
        case (style)
            0:       return $urandom;
            1:       return 32'($signed($urandom) >>> $urandom_range(1, 31));
            2:       return pool[$urandom_range(0, 4)];
            default: return 32'h0;
        endcase
    endfunction

    // A whole vector with random content, then a few reads; a read may also come before or during the loads.
    task automatic run_vector(int n_reads_after);
        int style;
        int tot;
        style = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
        tot   = sb.total();
        if ($urandom_range(0, 9) == 0) read(12'($urandom_range(0, tot - 1)));
        for (int k = 0; k < tot; k++) begin
            load(pick_sample(($urandom_range(0, 15) == 0) ? 2 : style));
            if (k < tot - 1 && $urandom_range(0, 99) == 0) read(12'($urandom));
        end
        for (int k = 0; k < n_reads_after; k++) begin
            if ($urandom_range(0, 6) == 0) read(12'($urandom));
            else read(12'($urandom_range(0, tot - 1)));
        end
    endtask

    initial begin
        int states;
        int points;
        bit [31:0] stp;
        sb = new();
        sb.reset_state();
        idle_on     = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_STATE_COUNT;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset settings, extreme samples, early and out-of-range reads.
        read(12'd0);
        load(32'h7FFF_FFFF);
        load(32'h8000_0000);
        read(12'd0);
        read(12'd1);
        read(12'hFFF);
        read(12'd2);
        // A load after completion starts a fresh vector.
        load(32'h0000_0001);
        load(32'hFFFF_FFFF);
        read(12'd1);
        load(32'h0);
        load(32'h0);
        read(12'd0);
        // Zero step gives a zero norm; the largest step is tried too.
        set_regs(7'd1, 13'd3, 32'h0);
        load(32'h4000_0000);
        load(32'hC000_0000);
        load(32'h1234_5678);
        read(12'd0);
        set_regs(7'd1, 13'd3, 32'hFFFF_FFFF);
        run_vector(3);
        // Invalid settings: loads ignored, reads refused.
        set_regs(7'd0, 13'd2, 32'h0100_0000);
        load(32'h1);
        read(12'd0);
        set_regs(7'd64, 13'd65, 32'h0100_0000);
        load(32'h1);
        read(12'd0);
        set_regs(7'd127, 13'h1FFF, 32'h0100_0000);
        read(12'd0);
        set_regs(7'd2, 13'd1, 32'h0100_0000);
        load(32'h1);
        read(12'd0);

        // Random settings, mostly small vectors.
        while (n_loads + n_reads < 700) begin
            states = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
            points = $urandom_range(2, 12);
            if (states * points > 128) points = (128 / states < 2) ? 2 : 128 / states;
            case ($urandom_range(0, 5))
                0:       stp = 32'($urandom_range(0, 255));
                1:       stp = 32'h0100_0000;
                default: stp = $urandom;
            endcase
            set_regs(7'(states), 13'(points), stp);
            for (int v = $urandom_range(1, 3); v > 0; v--) begin
                run_vector($urandom_range(1, 8));
                if ($urandom_range(0, 3) == 0) wait_drained();
            end
            // Stray beats between vectors.
            if ($urandom_range(0, 4) == 0) begin
                for (int k = $urandom_range(1, 3); k > 0; k--)
                    send(1'($urandom), pick_sample(0), 12'($urandom));
                run_vector(2);
            end
        end

        // Closing part without idling: 64 segments of two points, then longer segments.
        wait_drained();
        idle_on = 1'b0;
        set_regs(7'd64, 13'd2, $urandom);
        run_vector(8);
        set_regs(7'd8, 13'd16, 32'h0100_0000);
        run_vector(8);
        read(12'd4095);

        wait_drained();
        repeat (100) @(posedge i_clk);
        $display("covered %0d loads and %0d reads over %0d register settings",
                 n_loads, n_reads, n_settings);
        $display("%0d result beats checked, %0d mismatches", sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("** simpson_vector_normalizer: PASSED **");
        end else begin
            $display("** simpson_vector_normalizer: FAILED **");
        end
        $finish;
    end
endmodule
`default_nettype wire
